// ===== sv/lvrp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the linear velocity ramp profile block.
// No dependencies; imported by lvrp_div, linear_velocity_ramp_profile, lvrp_checker and tb_top.
package lvrp_pkg;

  localparam int RATE_W   = 23;
  localparam int STEP_W   = 32;
  localparam int STATUS_W = 2;
  localparam int KIND_W   = 3;
  localparam int DIR_W    = 2;
  localparam int IDX_W    = 2;

  typedef logic [RATE_W-1:0]   rate_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [KIND_W-1:0]   kind_t;
  typedef logic [DIR_W-1:0]    dir_t;
  typedef logic [IDX_W-1:0]    reg_idx_t;

  // request selector carried in in_tuser
  localparam logic REQ_START  = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  // result status
  localparam status_t STATUS_OK        = 2'd0;
  localparam status_t STATUS_RATE_ZERO = 2'd1;
  localparam status_t STATUS_SAT       = 2'd2;

  // last ramp kind, 3-bit two's complement
  localparam kind_t KIND_NONE    = 3'b000;
  localparam kind_t KIND_ACC_POS = 3'b001;
  localparam kind_t KIND_DEC_POS = 3'b010;
  localparam kind_t KIND_ACC_NEG = 3'b111;
  localparam kind_t KIND_DEC_NEG = 3'b110;

  // ramp direction, 2-bit two's complement
  localparam dir_t DIR_NONE = 2'b00;
  localparam dir_t DIR_UP   = 2'b01;
  localparam dir_t DIR_DOWN = 2'b11;

  // configuration register indexes
  localparam reg_idx_t REG_ACCEL_RATE     = 2'd0;
  localparam reg_idx_t REG_DECEL_RATE     = 2'd1;
  localparam reg_idx_t REG_VELOCITY_LIMIT = 2'd2;

  localparam rate_t ACCEL_RESET = 23'd1000;
  localparam rate_t DECEL_RESET = 23'd1000;
  localparam rate_t LIMIT_RESET = 23'd8388607;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLAMP,
    ST_SETUP,
    ST_MULT,
    ST_NUMER,
    ST_ABS,
    ST_DIV,
    ST_SAT,
    ST_DONE
  } state_t;

  // divider handshake toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== sv/lvrp_div.sv =====
`timescale 1ns / 1ps
// Iterative restoring divider, two quotient bits per cycle.
// Uses lvrp_pkg for the status struct; shared by ramp-length and sample math.
module lvrp_div
  import lvrp_pkg::*;
#(
  parameter int NUM_W = 60,
  parameter int DEN_W = 24
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output div_stat_t        stat,
  output logic [NUM_W-1:0] quotient
);

  localparam int ITERS = NUM_W / 2;
  localparam int CNT_W = $clog2(ITERS + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [NUM_W-1:0] quo_r;

  logic [DEN_W:0]   t1, t2, d1, d2;
  logic             ge1, ge2;
  logic [DEN_W-1:0] r1, r2;

  always_comb begin
    t1  = {rem_r, quo_r[NUM_W-1]};
    d1  = t1 - {1'b0, den_r};
    ge1 = (t1 >= {1'b0, den_r});
    r1  = ge1 ? d1[DEN_W-1:0] : t1[DEN_W-1:0];
    t2  = {r1, quo_r[NUM_W-2]};
    d2  = t2 - {1'b0, den_r};
    ge2 = (t2 >= {1'b0, den_r});
    r2  = ge2 ? d2[DEN_W-1:0] : t2[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CNT_W'(1));
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(ITERS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      quo_r <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[NUM_W-3:0], ge1, ge2};
      rem_r <= r2;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

// ===== sv/linear_velocity_ramp_profile.sv =====
`timescale 1ns / 1ps
// Linear velocity ramp profile: ramp length on start words, speed on sample words.
// Start words pass CLAMP, SETUP, MULT, NUMER, ABS, DIV, SAT and DONE; sample words
// skip CLAMP, and start words with equal speeds or a zero rate go from SETUP to DONE.
// One word at a time, so a new word is taken the cycle after the previous result enters
// the output register. The cost is set by the divider, 2 quotient bits a cycle.
// Reset (rst_n low, synchronous): rates 1000, limit 8388607, ramp state cleared.
module linear_velocity_ramp_profile
  import lvrp_pkg::*;
#(
  parameter int SAMPLES_PER_SECOND = 1000,
  parameter int SPEED_BITS         = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input words
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // [S-1:0] target_speed, [2S-1:S] present_speed, [2S+31:2S] step_index
  input  logic [((2 * SPEED_BITS + 32 + 7) / 8) * 8 - 1:0] in_tdata,
  // [0] req_type
  input  logic                 in_tuser,
  // result words
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // [31:0] step_count, [S+31:32] speed_sample
  output logic [((SPEED_BITS + 32 + 7) / 8) * 8 - 1:0] out_tdata,
  // [1:0] status
  output logic [STATUS_W-1:0]  out_tuser,
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [IDX_W-1:0]     cfg_index,
  input  logic [RATE_W-1:0]    cfg_data
);

  localparam int S      = SPEED_BITS;
  localparam int OUT_DW = ((SPEED_BITS + 32 + 7) / 8) * 8;

  // datapath widths
  localparam int SPS_W  = $clog2(SAMPLES_PER_SECOND + 1);
  localparam int PROD_W = STEP_W + RATE_W;               // shared multiplier output
  localparam int BASE_W = S + SPS_W + 1;                 // start_speed * SPS, signed
  localparam int V_W    = ((BASE_W > PROD_W + 1) ? BASE_W : PROD_W + 1) + 1;
  localparam int DVD_W  = V_W + 2;
  localparam int NUM_W  = DVD_W + (DVD_W % 2);           // even for radix-4 steps
  localparam int DEN_W  = ((SPS_W + 1) > (RATE_W + 1)) ? (SPS_W + 1) : (RATE_W + 1);
  localparam int CW     = ((S > RATE_W) ? S : RATE_W) + 2;

  localparam rate_t                    SPS_RATE = RATE_W'(SAMPLES_PER_SECOND);
  localparam logic signed [BASE_W-1:0] SPS_BASE = BASE_W'(SAMPLES_PER_SECOND);
  localparam logic [NUM_W-1:0]         SPS_ADD  = NUM_W'(SAMPLES_PER_SECOND);
  localparam logic [DEN_W-1:0]         SPS_DEN  = DEN_W'(2 * SAMPLES_PER_SECOND);
  localparam logic [NUM_W-1:0]         SPD_MIN_Q = NUM_W'(1) << (S - 1);
  localparam logic [NUM_W-1:0]         SPD_MAX_Q = SPD_MIN_Q - NUM_W'(1);

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  state_t state_r, state_nxt;

  rate_t accel_rate_r, decel_rate_r, velocity_limit_r;

  // ramp state kept between words
  logic signed [S-1:0] start_speed_r;
  dir_t                dir_r;
  rate_t               chosen_rate_r;
  kind_t               kind_r;

  // captured word and intermediate values
  logic                     req_r;
  logic signed [S-1:0]      tgt_r, present_r, tgt_c_r;
  logic [STEP_W-1:0]        step_r;
  logic [S-1:0]             diff_r;
  logic signed [BASE_W-1:0] base_r;
  logic [PROD_W-1:0]        prod_r;
  logic signed [V_W-1:0]    v_r;
  logic                     neg_r;

  // pending result and output register
  logic [STEP_W-1:0] res_step_r;
  logic [S-1:0]      res_speed_r;
  status_t           res_status_r;
  logic              out_valid_r;
  logic [STEP_W-1:0] out_step_r;
  logic [S-1:0]      out_speed_r;
  status_t           out_status_r;

  // ---------------------------------------------------------------------------
  // Combinational datapath
  // ---------------------------------------------------------------------------
  logic                     in_acc;
  logic                     div_go;
  div_stat_t                div_stat;
  logic [NUM_W-1:0]         quotient;

  logic signed [CW-1:0]     tgt_w, lim_w, nlim_w;
  logic signed [S-1:0]      tgt_clamp;

  logic                     u_zero, t_zero, u_neg, t_neg, t_gt_u, t_eq_u;
  rate_t                    rate_sel;
  kind_t                    kind_sel;
  logic [S:0]               sub_tu, sub_ut;
  logic                     setup_short;

  logic [STEP_W-1:0]        mul_a;
  rate_t                    mul_b;
  logic [PROD_W-1:0]        prod_nxt;
  logic signed [BASE_W-1:0] base_nxt;

  logic signed [V_W-1:0]    base_v, prod_v, v_nxt;
  logic signed [NUM_W-1:0]  v2;
  logic [NUM_W-1:0]         addend, dvd;
  logic [DEN_W-1:0]         den;

  logic [STEP_W-1:0]        sat_step;
  logic [S-1:0]             sat_speed;
  status_t                  sat_status;

  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // target clamp to +/- velocity_limit
  always_comb begin
    tgt_w  = CW'(tgt_r);
    lim_w  = signed'(CW'(velocity_limit_r));
    nlim_w = -lim_w;
    if (tgt_w >= lim_w) begin
      tgt_clamp = lim_w[S-1:0];
    end else if (tgt_w <= nlim_w) begin
      tgt_clamp = nlim_w[S-1:0];
    end else begin
      tgt_clamp = tgt_r;
    end
  end

  // rate and kind by sign quadrant; zero crossings use the last kind
  always_comb begin
    u_zero   = (present_r == '0);
    t_zero   = (tgt_c_r == '0);
    u_neg    = present_r[S-1];
    t_neg    = tgt_c_r[S-1];
    t_gt_u   = (tgt_c_r > present_r);
    t_eq_u   = (tgt_c_r == present_r);
    rate_sel = chosen_rate_r;
    kind_sel = kind_r;
    if (!u_neg && !t_neg) begin
      if (t_gt_u || t_eq_u) begin
        rate_sel = accel_rate_r;
        kind_sel = KIND_ACC_POS;
      end else begin
        rate_sel = decel_rate_r;
        kind_sel = KIND_DEC_POS;
      end
    end else if ((u_neg || u_zero) && (t_neg || t_zero)) begin
      if (u_zero) begin
        rate_sel = accel_rate_r;
        kind_sel = KIND_ACC_NEG;
      end else if (t_zero) begin
        rate_sel = decel_rate_r;
        kind_sel = KIND_DEC_NEG;
      end else if (!t_gt_u && !t_eq_u) begin
        rate_sel = accel_rate_r;
        kind_sel = KIND_ACC_NEG;
      end else if (t_gt_u) begin
        rate_sel = decel_rate_r;
        kind_sel = KIND_DEC_NEG;
      end
    end else if (!u_neg) begin
      // positive start crossing to a negative target
      if (kind_r == KIND_DEC_POS || kind_r == KIND_DEC_NEG) begin
        rate_sel = accel_rate_r;
        kind_sel = KIND_ACC_POS;
      end else begin
        rate_sel = decel_rate_r;
        kind_sel = KIND_DEC_POS;
      end
    end else begin
      if (kind_r == KIND_ACC_NEG) begin
        rate_sel = decel_rate_r;
        kind_sel = KIND_DEC_NEG;
      end else begin
        rate_sel = accel_rate_r;
        kind_sel = KIND_ACC_NEG;
      end
    end
    sub_tu      = {tgt_c_r[S-1], tgt_c_r} - {present_r[S-1], present_r};
    sub_ut      = {present_r[S-1], present_r} - {tgt_c_r[S-1], tgt_c_r};
    setup_short = (req_r == REQ_START) && (t_eq_u || (rate_sel == '0));
  end

  // shared multiplier: diff*SPS on start, rate*step on sample
  always_comb begin
    mul_a    = (req_r == REQ_START) ? STEP_W'(diff_r) : step_r;
    mul_b    = (req_r == REQ_START) ? SPS_RATE : chosen_rate_r;
    prod_nxt = PROD_W'(mul_a) * PROD_W'(mul_b);
    base_nxt = BASE_W'(start_speed_r) * SPS_BASE;
  end

  // signed numerator, then 2*|v| + addend as one add or subtract
  always_comb begin
    base_v = V_W'(base_r);
    prod_v = signed'(V_W'(prod_r));
    if (req_r == REQ_START) begin
      v_nxt = prod_v;
    end else begin
      case (dir_r)
        DIR_UP:   v_nxt = base_v + prod_v;
        DIR_DOWN: v_nxt = base_v - prod_v;
        default:  v_nxt = base_v;
      endcase
    end
    v2     = NUM_W'(v_r) <<< 1;
    addend = (req_r == REQ_START) ? NUM_W'(chosen_rate_r) : SPS_ADD;
    dvd    = v_r[V_W-1] ? (addend - unsigned'(v2)) : (unsigned'(v2) + addend);
    den    = (req_r == REQ_START) ? DEN_W'({chosen_rate_r, 1'b0}) : SPS_DEN;
  end

  // saturation of the quotient
  always_comb begin
    sat_step   = '0;
    sat_speed  = '0;
    sat_status = STATUS_OK;
    if (req_r == REQ_START) begin
      sat_step = (quotient[NUM_W-1:STEP_W] != '0) ? '1 : quotient[STEP_W-1:0];
    end else if (neg_r) begin
      if (quotient > SPD_MIN_Q) begin
        sat_speed  = SPD_MIN_Q[S-1:0];
        sat_status = STATUS_SAT;
      end else begin
        sat_speed = -quotient[S-1:0];
      end
    end else begin
      if (quotient > SPD_MAX_Q) begin
        sat_speed  = SPD_MAX_Q[S-1:0];
        sat_status = STATUS_SAT;
      end else begin
        sat_speed = quotient[S-1:0];
      end
    end
  end

  lvrp_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go),
    .dividend (dvd),
    .divisor  (den),
    .stat     (div_stat),
    .quotient (quotient)
  );

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    div_go    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = (in_tuser == REQ_START) ? ST_CLAMP : ST_SETUP;
        end
      end
      ST_CLAMP: state_nxt = ST_SETUP;
      ST_SETUP: state_nxt = setup_short ? ST_DONE : ST_MULT;
      ST_MULT:  state_nxt = ST_NUMER;
      ST_NUMER: state_nxt = ST_ABS;
      ST_ABS: begin
        div_go    = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_nxt = ST_SAT;
        end
      end
      ST_SAT: state_nxt = ST_DONE;
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Configuration and ramp state
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_rate_r     <= ACCEL_RESET;
      decel_rate_r     <= DECEL_RESET;
      velocity_limit_r <= LIMIT_RESET;
      start_speed_r    <= '0;
      dir_r            <= DIR_NONE;
      chosen_rate_r    <= '0;
      kind_r           <= KIND_NONE;
      out_valid_r      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ACCEL_RATE:     accel_rate_r     <= cfg_data;
          REG_DECEL_RATE:     decel_rate_r     <= cfg_data;
          REG_VELOCITY_LIMIT: velocity_limit_r <= cfg_data;
          default:            ;
        endcase
      end
      if (state_r == ST_SETUP && req_r == REQ_START) begin
        start_speed_r <= present_r;
        chosen_rate_r <= rate_sel;
        kind_r        <= kind_sel;
        if (t_eq_u) begin
          dir_r <= DIR_NONE;
        end else begin
          dir_r <= t_gt_u ? DIR_UP : DIR_DOWN;
        end
      end
      if (state_r == ST_DONE && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r     <= in_tuser;
      tgt_r     <= in_tdata[S-1:0];
      present_r <= in_tdata[2*S-1:S];
      step_r    <= in_tdata[2*S+STEP_W-1:2*S];
    end
    if (state_r == ST_CLAMP) begin
      tgt_c_r <= tgt_clamp;
    end
    if (state_r == ST_SETUP) begin
      diff_r <= t_gt_u ? sub_tu[S-1:0] : sub_ut[S-1:0];
      base_r <= base_nxt;
      if (req_r == REQ_START) begin
        res_step_r   <= (t_eq_u) ? '0 : '1;
        res_speed_r  <= '0;
        res_status_r <= (t_eq_u) ? STATUS_OK : STATUS_RATE_ZERO;
      end
    end
    if (state_r == ST_MULT) begin
      prod_r <= prod_nxt;
    end
    if (state_r == ST_NUMER) begin
      v_r <= v_nxt;
    end
    if (state_r == ST_ABS) begin
      neg_r <= v_r[V_W-1];
    end
    if (state_r == ST_SAT) begin
      res_step_r   <= sat_step;
      res_speed_r  <= sat_speed;
      res_status_r <= sat_status;
    end
    if (state_r == ST_DONE && (!out_valid_r || out_tready)) begin
      out_step_r   <= res_step_r;
      out_speed_r  <= res_speed_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DW'({out_speed_r, out_step_r});
  assign out_tuser  = out_status_r;

endmodule

// ===== verif/lvrp_checker.sv =====
`timescale 1ns / 1ps
// Checker for linear_velocity_ramp_profile: snoops config, input and result channels,
// predicts each result word and compares it. Depends on lvrp_pkg.
module lvrp_checker
  import lvrp_pkg::*;
#(
  parameter int SAMPLES_PER_SEC = 1000
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [79:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [55:0] out_tdata,
  input  status_t     out_tuser,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  reg_idx_t    cfg_index,
  input  rate_t       cfg_data,
  output int          pending,
  output int          mismatches
);

  localparam longint SPEED_HI = 64'sd8388607;
  localparam longint SPEED_LO = -64'sd8388608;

  typedef struct packed {
    logic [31:0] steps;
    logic [23:0] speed;
    status_t     status;
  } ramp_result_t;

  rate_t accel_q, decel_q, limit_q;

  // ramp state
  logic signed [23:0] base_speed;
  dir_t               heading;
  rate_t              ramp_rate;
  kind_t              prev_kind;

  ramp_result_t ramp_results_q[$];
  int           miss_cnt = 0;

  function automatic ramp_result_t plan_ramp(input logic signed [23:0] tgt_w,
                                             input logic signed [23:0] pres_w);
    longint lim, tgt, u, diff, q;
    ramp_result_t r;
    r   = '0;
    lim = limit_q;
    tgt = tgt_w;
    u   = pres_w;
    if (tgt >= lim) tgt = lim;
    else if (tgt <= -lim) tgt = -lim;

    // rate choice by sign quadrant; crossings look at the previous kind
    if (u >= 0 && tgt >= 0) begin
      if (tgt >= u) begin
        ramp_rate = accel_q; prev_kind = KIND_ACC_POS;
      end else begin
        ramp_rate = decel_q; prev_kind = KIND_DEC_POS;
      end
    end else if (u <= 0 && tgt <= 0) begin
      if (u == 0) begin
        ramp_rate = accel_q; prev_kind = KIND_ACC_NEG;
      end else if (tgt == 0) begin
        ramp_rate = decel_q; prev_kind = KIND_DEC_NEG;
      end else if (tgt < u) begin
        ramp_rate = accel_q; prev_kind = KIND_ACC_NEG;
      end else if (tgt > u) begin
        ramp_rate = decel_q; prev_kind = KIND_DEC_NEG;
      end
      // equal negative speeds keep rate and kind
    end else if (u > 0) begin
      if (prev_kind == KIND_DEC_POS || prev_kind == KIND_DEC_NEG) begin
        ramp_rate = accel_q; prev_kind = KIND_ACC_POS;
      end else begin
        ramp_rate = decel_q; prev_kind = KIND_DEC_POS;
      end
    end else begin
      if (prev_kind == KIND_ACC_NEG) begin
        ramp_rate = decel_q; prev_kind = KIND_DEC_NEG;
      end else begin
        ramp_rate = accel_q; prev_kind = KIND_ACC_NEG;
      end
    end

    base_speed = pres_w;
    if (tgt == u) begin
      heading = DIR_NONE;
    end else begin
      heading = (tgt > u) ? DIR_UP : DIR_DOWN;
      diff    = (tgt > u) ? tgt - u : u - tgt;
      if (ramp_rate == '0) begin
        r.steps  = '1;
        r.status = STATUS_RATE_ZERO;
      end else begin
        q = (2 * diff * SAMPLES_PER_SEC + longint'(ramp_rate)) / (2 * longint'(ramp_rate));
        r.steps = (q > 64'sh0FFFFFFFF) ? '1 : q[31:0];
      end
    end
    return r;
  endfunction

  function automatic ramp_result_t sample_ramp(input logic [31:0] step);
    longint delta, num, mag, q, res;
    ramp_result_t r;
    r     = '0;
    delta = longint'(ramp_rate) * longint'(step);
    num   = longint'(base_speed) * SAMPLES_PER_SEC;
    if (heading == DIR_UP) num = num + delta;
    else if (heading == DIR_DOWN) num = num - delta;
    // round half away from zero
    mag = (num < 0) ? -num : num;
    q   = (2 * mag + SAMPLES_PER_SEC) / (2 * SAMPLES_PER_SEC);
    res = (num < 0) ? -q : q;
    if (res > SPEED_HI) begin
      res = SPEED_HI; r.status = STATUS_SAT;
    end else if (res < SPEED_LO) begin
      res = SPEED_LO; r.status = STATUS_SAT;
    end
    r.speed = res[23:0];
    return r;
  endfunction

  always @(posedge clk) begin
    ramp_result_t seen, want;
    if (!rst_n) begin
      accel_q    <= ACCEL_RESET;
      decel_q    <= DECEL_RESET;
      limit_q    <= LIMIT_RESET;
      base_speed = '0;
      heading    = DIR_NONE;
      ramp_rate  = '0;
      prev_kind  = KIND_NONE;
      ramp_results_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ACCEL_RATE:     accel_q <= cfg_data;
          REG_DECEL_RATE:     decel_q <= cfg_data;
          REG_VELOCITY_LIMIT: limit_q <= cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser == REQ_START)
          ramp_results_q.push_back(plan_ramp(in_tdata[23:0], in_tdata[47:24]));
        else
          ramp_results_q.push_back(sample_ramp(in_tdata[79:48]));
      end
      if (out_tvalid && out_tready) begin
        seen = {out_tdata[31:0], out_tdata[55:32], out_tuser};
        if (ramp_results_q.size() == 0) begin
          if (miss_cnt < 10)
            $display("%0t: result word with none pending: steps=%0d speed=%0d status=%0d",
                     $time, seen.steps, $signed(seen.speed), seen.status);
          miss_cnt++;
        end else begin
          want = ramp_results_q.pop_front();
          if (seen.steps !== want.steps || seen.speed !== want.speed ||
              seen.status !== want.status) begin
            if (miss_cnt < 10)
              $display("%0t: mismatch: exp steps=%0d speed=%0d status=%0d, got steps=%0d speed=%0d status=%0d",
                       $time, want.steps, $signed(want.speed), want.status,
                       seen.steps, $signed(seen.speed), seen.status);
            miss_cnt++;
          end
        end
      end
    end
    pending    <= ramp_results_q.size();
    mismatches <= miss_cnt;
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the linear_velocity_ramp_profile testbench: clock, reset, stimulus and verdict.
// Depends on lvrp_pkg, linear_velocity_ramp_profile and lvrp_checker.
module tb_top;
  import lvrp_pkg::*;

  localparam int          IN_W            = 80;   // target, present, step_index
  localparam int          OUT_W           = 56;   // step_count, speed_sample
  localparam reg_idx_t    REG_SPARE       = 2'd3; // index past the register list
  localparam rate_t       RATE_MAX        = 23'h7FFFFF;
  localparam logic [23:0] SPEED_POS_MAX   = 24'h7FFFFF;
  localparam logic [23:0] SPEED_NEG_MAX   = 24'h800000;
  localparam int          PHASES          = 12;
  localparam int          ITEMS_PER_PHASE = 155;
  localparam int          SETTLE_CYCLES   = 8;    // after the last result, before a cfg write
  localparam int          TAIL_CYCLES     = 60;   // > one full word latency

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata   = '0;
  logic              in_tuser   = REQ_START;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_W-1:0]  out_tdata;
  status_t           out_tuser;
  logic              cfg_valid  = 1'b0;
  logic              cfg_ready;
  reg_idx_t          cfg_index  = REG_ACCEL_RATE;
  rate_t             cfg_data   = '0;

  int pending;
  int mismatches;
  int burst_left = 0;
  int rx_mode    = 0;
  int rx_left    = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  linear_velocity_ramp_profile dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  lvrp_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pending    (pending),
    .mismatches (mismatches)
  );

  // Result side backpressure: modes switch at random between always ready, mostly ready,
  // mostly stalled and long stalls.
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_left <= $urandom_range(50, 400);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= ($urandom_range(0, 3) != 0);
      2:       out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= ($urandom_range(0, 39) == 0);
    endcase
  end

  // Speeds: extremes, zero, full random, or a log-spread magnitude with random sign.
  function automatic logic [23:0] pick_speed();
    logic [23:0] mag;
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 3))
          0:       return SPEED_POS_MAX;
          1:       return SPEED_NEG_MAX;
          2:       return 24'd1;
          default: return '1;
        endcase
      end
      1: return '0;
      2: return 24'($urandom);
      default: begin
        mag = 24'($urandom) & ((24'd1 << $urandom_range(0, 23)) - 24'd1);
        return $urandom_range(0, 1) ? -mag : mag;
      end
    endcase
  endfunction

  function automatic rate_t pick_rate();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return RATE_MAX;
      2:       return 23'd1;
      default: return 23'($urandom & ((32'd1 << $urandom_range(1, 23)) - 32'd1));
    endcase
  endfunction

  // Log-spread step index so short ramps and saturating ones both show up.
  function automatic logic [31:0] pick_step();
    int k;
    k = $urandom_range(0, 32);
    if (k == 32) return $urandom;
    return $urandom & ((32'd1 << k) - 32'd1);
  endfunction

  // Called at a clock edge; returns at the edge where the word is taken.
  // Bursts of random length, separated (usually) by random gaps.
  task automatic send_word(input logic req, input logic [23:0] tgt,
                           input logic [23:0] pres, input logic [31:0] step);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 2) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 45)) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {step, pres, tgt};
    do @(posedge clk); while (!in_tready);
  endtask

  // unused fields carry random bits; the block must ignore them
  task automatic send_start(input logic [23:0] tgt, input logic [23:0] pres);
    send_word(REQ_START, tgt, pres, $urandom);
  endtask

  task automatic send_sample(input logic [31:0] step);
    send_word(REQ_SAMPLE, 24'($urandom), 24'($urandom), step);
  endtask

  // Hold off until every pending result word is back, then let the block settle.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input rate_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int          n;
    logic [23:0] tgt, pres;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed, reset rates 1000/1000, limit at max ---
    send_sample(32'd0);                      // no ramp yet: zero
    send_sample(32'hFFFFFFFF);
    send_start(24'd0, 24'd0);                // equal speeds, zero length
    send_sample(32'd12345);
    send_start(SPEED_POS_MAX, SPEED_NEG_MAX); // crossing up from full negative
    send_sample(32'd0);
    send_sample(32'hFFFFFFFF);               // runs off the top, saturates
    send_start(SPEED_NEG_MAX, SPEED_POS_MAX); // target clamped to -limit
    send_sample(32'hFFFFFFFF);               // saturates at the bottom
    send_start(SPEED_POS_MAX, -24'sd1);      // crossing up after a decel
    send_start(-24'sd100, 24'sd50);          // crossing down after a neg accel
    send_start(24'sd70, -24'sd30);           // crossing up after a pos decel
    send_start(-24'sd40, -24'sd40);          // equal negatives: rate and kind kept
    send_start(-24'sd500, 24'sd0);           // from standstill into negative
    send_start(24'sd0, -24'sd500);           // negative back to standstill
    send_start(-24'sd3, 24'sd5);             // crossing down after a neg decel
    send_start(24'sd100, -24'sd1);
    send_start(-24'sd1000, -24'sd200);       // speeding up in negative
    send_start(-24'sd200, -24'sd1000);       // slowing down in negative
    send_start(24'sd5, 24'sd1);
    send_start(24'sd1, 24'sd5);

    // half-unit samples round away from zero
    drain();
    write_reg(REG_ACCEL_RATE, 23'd500);
    send_start(24'sd100, 24'sd0);
    send_sample(32'd1);
    send_start(-24'sd100, 24'sd0);
    send_sample(32'd1);

    // --- random phases, each opened with a full drain and, mostly, new register values ---
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph)
        0: begin
          write_reg(REG_ACCEL_RATE, '0);     // zero rate flag on accel ramps
          write_reg(REG_DECEL_RATE, 23'd1);  // huge ramp lengths, count saturates
          write_reg(REG_VELOCITY_LIMIT, RATE_MAX);
        end
        1: begin
          write_reg(REG_ACCEL_RATE, RATE_MAX);
          write_reg(REG_DECEL_RATE, '0);
          write_reg(REG_VELOCITY_LIMIT, '0); // every target clamps to zero
        end
        2: begin
          write_reg(REG_ACCEL_RATE, 23'd1);
          write_reg(REG_DECEL_RATE, RATE_MAX);
          write_reg(REG_VELOCITY_LIMIT, pick_rate());
        end
        default: begin
          if ($urandom_range(0, 2) != 0) write_reg(REG_ACCEL_RATE, pick_rate());
          if ($urandom_range(0, 2) != 0) write_reg(REG_DECEL_RATE, pick_rate());
          if ($urandom_range(0, 2) != 0) write_reg(REG_VELOCITY_LIMIT, pick_rate());
          if (ph == 5) write_reg(REG_SPARE, 23'($urandom));  // must be ignored
        end
      endcase

      n = 0;
      while (n < ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 9) == 0) begin
          // stray word with arbitrary content
          if ($urandom_range(0, 1)) send_sample($urandom);
          else send_start(24'($urandom), 24'($urandom));
          n++;
        end else begin
          // a ramp start followed by a few samples along it
          pres = pick_speed();
          tgt  = ($urandom_range(0, 7) == 0) ? pres : pick_speed();
          send_start(tgt, pres);
          n++;
          repeat ($urandom_range(0, 6)) begin
            send_sample(pick_step());
            n++;
          end
        end
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("linear_velocity_ramp_profile test passed");
    else
      $display("linear_velocity_ramp_profile test failed");
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #40_000_000;
    $display("linear_velocity_ramp_profile test failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/lvrp_pkg.sv
sv/lvrp_div.sv
sv/linear_velocity_ramp_profile.sv
verif/lvrp_checker.sv
verif/tb_top.sv
